/* rtl/core/sdspi_pkg.sv */
// Package: shared types, constants and command table for the SD SPI command engine.
`timescale 1ns / 1ps

package sdspi_pkg;

    localparam int N_CMDS = 26;

    localparam logic [7:0] BYTE_IDLE = 8'hFF;
    localparam logic [7:0] CRC_CMD0  = 8'h95;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Response formats
    typedef enum logic [1:0] {
        RT_R1  = 2'd0,
        RT_R1B = 2'd1,
        RT_R2  = 2'd2,
        RT_R3  = 2'd3
    } t_rtype;

    // Frame / response phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE = 9'b000000001,
        PH_ARG  = 9'b000000010,
        PH_CRC  = 9'b000000100,
        PH_FILL = 9'b000001000,
        PH_READ = 9'b000010000,
        PH_R1   = 9'b000100000,
        PH_BUSY = 9'b001000000,
        PH_R2LO = 9'b010000000,
        PH_OCR  = 9'b100000000
    } t_phase;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_RX    = 1'b1
    } t_mode;

    typedef struct packed {
        logic        mode;
        logic [4:0]  command;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        select;
        logic        done_res;
        logic [15:0] response;
        logic [31:0] ocr;
        logic        item_error;
    } t_out_item;

    typedef struct packed {
        logic [7:0] opcode;
        logic       has_arg;
        t_rtype     rtype;
    } t_cmd_entry;

    // Engine state carried between items
    typedef struct packed {
        t_phase      phase;
        logic [1:0]  byte_cnt;
        logic        has_arg;
        t_rtype      rtype;
        logic        cmd0;
        logic [31:0] argument;
        logic [7:0]  first_resp;
        logic [31:0] ocr_acc;
    } t_state;

    function automatic t_cmd_entry cmd_lookup(input logic [4:0] idx);
        t_cmd_entry e;
        e = '{opcode: 8'h40, has_arg: 1'b0, rtype: RT_R1};
        case (idx)
            5'd0:  e = '{8'h40, 1'b0, RT_R1};
            5'd1:  e = '{8'h41, 1'b0, RT_R1};
            5'd2:  e = '{8'h49, 1'b0, RT_R1};
            5'd3:  e = '{8'h4A, 1'b0, RT_R1};
            5'd4:  e = '{8'h4C, 1'b0, RT_R1};
            5'd5:  e = '{8'h4D, 1'b0, RT_R2};
            5'd6:  e = '{8'h50, 1'b1, RT_R1};
            5'd7:  e = '{8'h51, 1'b1, RT_R1};
            5'd8:  e = '{8'h52, 1'b1, RT_R1};
            5'd9:  e = '{8'h58, 1'b1, RT_R1};
            5'd10: e = '{8'h59, 1'b1, RT_R1};
            5'd11: e = '{8'h5B, 1'b0, RT_R1};
            5'd12: e = '{8'h5C, 1'b1, RT_R1B};
            5'd13: e = '{8'h5D, 1'b1, RT_R1B};
            5'd14: e = '{8'h5E, 1'b1, RT_R1};
            5'd15: e = '{8'h60, 1'b1, RT_R1};
            5'd16: e = '{8'h61, 1'b1, RT_R1};
            5'd17: e = '{8'h62, 1'b1, RT_R1};
            5'd18: e = '{8'h63, 1'b1, RT_R1};
            5'd19: e = '{8'h64, 1'b1, RT_R1};
            5'd20: e = '{8'h65, 1'b1, RT_R1};
            5'd21: e = '{8'h66, 1'b1, RT_R1B};
            5'd22: e = '{8'h6A, 1'b1, RT_R1B};
            5'd23: e = '{8'h7A, 1'b0, RT_R3};
            5'd24: e = '{8'h7B, 1'b1, RT_R1};
            5'd25: e = '{8'h69, 1'b0, RT_R1};
            default: e = '{8'h40, 1'b0, RT_R1};
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/sd_spi_command_engine_unit.sv */
// Top level of the SD-card SPI-mode command engine.
`timescale 1ns / 1ps

// SD-card SPI-mode command engine. Each item is one SPI byte exchange: a start
// item (mode 0) picks one of 26 table commands and its 32-bit argument and
// returns the opcode to send; each later item (mode 1) hands in the byte just
// received and returns the next byte to send (argument bytes MSB first, or 0x00
// for commands without an argument, CRC 0x95 for CMD0 else 0xFF, one 0xFF
// filler, then 0xFF while the R1, R1b, R2 or R3 response is collected). One
// result item per input item. Items that do not fit the current phase, or name
// a command above 25, come back with item_error set and leave the state alone.
// Throughput is one item per clock while the output is not stalled, since the
// state update in sdspi_step is combinational. An item enters the input
// register when accepted and its result the result register once that slot is
// free or draining. While a result waits on a stalled output, the input
// register takes one more item and the input then stalls until the result is taken.

module sd_spi_command_engine_unit
    import sdspi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_state    n_state;
    t_out_item n_out_item;
    logic      w_fire;

    // item in the input register moves on when the result slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    sdspi_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, byte_cnt: 2'd0, has_arg: 1'b0, rtype: RT_R1,
                         cmd0: 1'b1, argument: 32'h0, first_resp: 8'h00,
                         ocr_acc: 32'h0};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/core/sdspi_step.sv */
// Next-state and result logic for one item of the SD SPI command engine.
`timescale 1ns / 1ps

module sdspi_step
    import sdspi_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    t_cmd_entry  w_entry;
    logic [31:0] w_ocr_next;
    logic [7:0]  w_arg_byte;

    assign w_entry    = cmd_lookup(i_item.command);
    assign w_ocr_next = {i_state.ocr_acc[23:0], i_item.rx_byte};

    always_comb begin
        case (i_state.byte_cnt)
            2'd0:    w_arg_byte = i_state.argument[31:24];
            2'd1:    w_arg_byte = i_state.argument[23:16];
            2'd2:    w_arg_byte = i_state.argument[15:8];
            default: w_arg_byte = i_state.argument[7:0];
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{tx_byte: BYTE_IDLE, select: 1'b0, done_res: 1'b0,
                     response: 16'h0000, ocr: 32'h0, item_error: 1'b0};

        if (i_item.mode == MODE_START) begin
            if (i_state.phase != PH_IDLE) begin
                o_result.item_error = 1'b1;
                o_result.select     = 1'b1;
            end else if (i_item.command >= 5'(N_CMDS)) begin
                o_result.item_error = 1'b1;
            end else begin
                o_state.has_arg  = w_entry.has_arg;
                o_state.rtype    = w_entry.rtype;
                o_state.cmd0     = (i_item.command == 5'd0);
                o_state.argument = i_item.argument;
                o_state.byte_cnt = 2'd0;
                o_state.phase    = PH_ARG;
                o_result.tx_byte = w_entry.opcode;
                o_result.select  = 1'b1;
            end
        end else if (i_state.phase == PH_IDLE) begin
            o_result.item_error = 1'b1;
        end else begin
            o_result.select = 1'b1;
            unique case (i_state.phase)
                PH_ARG: begin
                    o_result.tx_byte = i_state.has_arg ? w_arg_byte : BYTE_ZERO;
                    o_state.byte_cnt = i_state.byte_cnt + 2'd1;
                    if (i_state.byte_cnt == 2'd3) begin
                        o_state.phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    o_result.tx_byte = i_state.cmd0 ? CRC_CMD0 : BYTE_IDLE;
                    o_state.phase    = PH_FILL;
                end
                PH_FILL: o_state.phase = PH_READ;
                PH_READ: o_state.phase = PH_R1;
                PH_R1: begin
                    case (i_state.rtype)
                        RT_R1: begin
                            o_result.done_res = 1'b1;
                            o_result.response = {8'h00, i_item.rx_byte};
                            o_state.phase     = PH_IDLE;
                        end
                        RT_R1B: begin
                            o_state.first_resp = i_item.rx_byte;
                            o_state.phase      = PH_BUSY;
                        end
                        RT_R2: begin
                            // high byte of R2 kept until the low byte arrives
                            o_state.first_resp = i_item.rx_byte;
                            o_state.phase      = PH_R2LO;
                        end
                        default: begin
                            o_state.first_resp = i_item.rx_byte;
                            o_state.ocr_acc    = 32'h0;
                            o_state.byte_cnt   = 2'd0;
                            o_state.phase      = PH_OCR;
                        end
                    endcase
                end
                PH_BUSY: begin
                    if (i_item.rx_byte != BYTE_ZERO) begin
                        o_result.done_res = 1'b1;
                        o_result.response = {8'h00, i_state.first_resp};
                        o_state.phase     = PH_IDLE;
                    end
                end
                PH_R2LO: begin
                    o_result.done_res = 1'b1;
                    o_result.response = {i_state.first_resp, i_item.rx_byte};
                    o_state.phase     = PH_IDLE;
                end
                PH_OCR: begin
                    o_state.ocr_acc  = w_ocr_next;
                    o_state.byte_cnt = i_state.byte_cnt + 2'd1;
                    if (i_state.byte_cnt == 2'd3) begin
                        o_result.done_res = 1'b1;
                        o_result.response = {8'h00, i_state.first_resp};
                        o_result.ocr      = w_ocr_next;
                        o_state.phase     = PH_IDLE;
                    end
                end
                default: o_state.phase = PH_IDLE;
            endcase
        end
    end

endmodule
